// ===== hw/rtl/rct_pkg.sv =====
// Shared types, constants and arithmetic helpers for the reversible color transform.
package rct_pkg;

   localparam int COMP_W   = 19;
   localparam int WIDE_W   = COMP_W + 5;
   localparam int BYTE_W   = 8;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 3;
   localparam int MOD_BASE = 256;

   localparam logic signed [WIDE_W-1:0] COMP_MAX_W =
      WIDE_W'((64'sd1 <<< (COMP_W - 1)) - 64'sd1);
   localparam logic signed [WIDE_W-1:0] COMP_MIN_W = -(COMP_MAX_W + WIDE_W'(1));
   localparam logic signed [WIDE_W-1:0] MOD_BASE_W = WIDE_W'(MOD_BASE);

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef enum logic [2:0] {
      MODE_RAW     = 3'd0,
      MODE_RCT     = 3'd1,
      MODE_YCOCG_R = 3'd2,
      MODE_RDGDB   = 3'd3,
      MODE_LDGEB   = 3'd4,
      MODE_MRDGDB  = 3'd5,
      MODE_MLDGEB  = 3'd6,
      MODE_LOCO_I  = 3'd7
   } mode_type;

   typedef enum logic {
      DIR_FORWARD = 1'b0,
      DIR_INVERSE = 1'b1
   } dir_type;

   localparam logic [CSR_IW-1:0] CSR_MODE = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] CSR_DIR  = CSR_IW'(1);

   // halve, rounding toward zero
   function automatic wide_type half_trunc(input wide_type v);
      wide_type sum;
      sum = v + $signed({{(WIDE_W-1){1'b0}}, v[WIDE_W-1]});
      return sum >>> 1;
   endfunction

   // true modulo 256, result 0..255
   function automatic wide_type umod8(input wide_type v);
      return $signed({{(WIDE_W-BYTE_W){1'b0}}, v[BYTE_W-1:0]});
   endfunction

   // signed modulo 256, result -128..127
   function automatic wide_type smod8(input wide_type v);
      return $signed({{(WIDE_W-BYTE_W){v[BYTE_W-1]}}, v[BYTE_W-1:0]});
   endfunction

   function automatic comp_type sat_comp(input wide_type v);
      comp_type r;
      if (v > COMP_MAX_W) begin
         r = COMP_MAX_W[COMP_W-1:0];
      end else if (v < COMP_MIN_W) begin
         r = COMP_MIN_W[COMP_W-1:0];
      end else begin
         r = v[COMP_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/reversible_color_transform_core.sv =====
// Reversible color transform core: one pixel in, three transformed components out.
//
// Usage:
//   Input: drive req_comp0..2 and raise start. A pixel transfers at a rising
//   edge where start is high and busy is low. busy stays low, so one pixel
//   may transfer in every cycle.
//   Output: the edge after the input transfer raises rsp_strobe, and
//   rsp_out0..2 and rsp_range_error hold the result for that one cycle; the
//   result transfers at the next edge.
//   The receiver takes every result; there is no stall path.
//   A pixel passes the input register, then the result register; throughput
//   is one pixel per cycle, set by the single combinational pass between them.
//   Configuration: csr_index 0 selects transform_mode, 1 selects direction;
//   a write transfers when csr_valid and csr_ready are high (csr_ready stays
//   high). Other indexes are dropped. Write only while no pixel is in flight.
//   Reset (synchronous, active high) clears both pipeline valids and returns
//   the mode to raw pass-through, forward.
module reversible_color_transform_core
   import rct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [COMP_W-1:0] req_comp0,
   input  logic signed [COMP_W-1:0] req_comp1,
   input  logic signed [COMP_W-1:0] req_comp2,
   output logic                 rsp_strobe,
   output logic signed [COMP_W-1:0] rsp_out0,
   output logic signed [COMP_W-1:0] rsp_out1,
   output logic signed [COMP_W-1:0] rsp_out2,
   output logic                 rsp_range_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IW-1:0]    csr_index,
   input  logic [CSR_DW-1:0]    csr_data
);

   mode_type mode_ff;
   dir_type  dir_ff;

   logic     in_valid_ff;
   comp_type comp0_ff, comp1_ff, comp2_ff;

   logic     out_valid_ff;
   comp_type out0_ff, out1_ff, out2_ff;
   logic     err_ff;

   comp_type out0_in, out1_in, out2_in;
   logic     err_in;

   wide_type a, b, c, x, y, z, t, u;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RAW;
         dir_ff  <= DIR_FORWARD;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE: mode_ff <= mode_type'(csr_data);
            CSR_DIR:  dir_ff  <= dir_type'(csr_data[0]);
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start && !busy;
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         comp0_ff <= req_comp0;
         comp1_ff <= req_comp1;
         comp2_ff <= req_comp2;
      end
      if (in_valid_ff) begin
         out0_ff <= out0_in;
         out1_ff <= out1_in;
         out2_ff <= out2_in;
         err_ff  <= err_in;
      end
   end

   always_comb begin
      a = WIDE_W'(comp0_ff);
      b = WIDE_W'(comp1_ff);
      c = WIDE_W'(comp2_ff);
      x = a;
      y = b;
      z = c;
      t = '0;
      u = '0;
      err_in = 1'b0;
      case (mode_ff)
         MODE_RCT: begin
            if (dir_ff == DIR_FORWARD) begin
               x = (a + (b <<< 1) + c) >>> 2;
               y = c - b;
               z = a - b;
            end else begin
               t = a - ((b + c) >>> 2);
               x = c + t;
               y = t;
               z = b + t;
            end
         end
         MODE_YCOCG_R: begin
            if (dir_ff == DIR_FORWARD) begin
               u = a - c;
               t = c + half_trunc(u);
               z = b - t;
               x = t + half_trunc(z);
               y = u;
            end else begin
               t = a - half_trunc(c);
               u = t - half_trunc(b);
               x = u + b;
               y = c + t;
               z = u;
            end
         end
         MODE_RDGDB: begin
            y = a - b;
            if (dir_ff == DIR_FORWARD) begin
               z = b - c;
            end else begin
               z = (a - b) - c;
            end
         end
         MODE_LDGEB: begin
            if (dir_ff == DIR_FORWARD) begin
               y = a - b;
               x = a - half_trunc(y);
               z = c - x;
            end else begin
               x = a + half_trunc(b);
               y = x - b;
               z = c + a;
            end
         end
         MODE_MRDGDB: begin
            if (dir_ff == DIR_FORWARD) begin
               if (a >= MOD_BASE_W || b >= MOD_BASE_W || c >= MOD_BASE_W) begin
                  err_in = 1'b1;
                  x = '0;
                  y = '0;
                  z = '0;
               end else begin
                  y = smod8(a - b);
                  z = smod8(b - c);
               end
            end else begin
               y = umod8(a - b);
               z = umod8(y - c);
            end
         end
         MODE_MLDGEB: begin
            if (dir_ff == DIR_FORWARD) begin
               if (a >= MOD_BASE_W || b >= MOD_BASE_W || c >= MOD_BASE_W) begin
                  err_in = 1'b1;
                  x = '0;
                  y = '0;
                  z = '0;
               end else begin
                  y = smod8(a - b);
                  x = umod8(a - (y >>> 1));
                  z = smod8(c - x);
               end
            end else begin
               x = umod8(a + (b >>> 1));
               y = umod8(x - b);
               z = umod8(c + a);
            end
         end
         MODE_LOCO_I: begin
            if (dir_ff == DIR_FORWARD) begin
               x = b;
               y = a - b;
               z = c - b;
            end else begin
               x = b + a;
               y = a;
               z = c + a;
            end
         end
         default: ;
      endcase
      out0_in = sat_comp(x);
      out1_in = sat_comp(y);
      out2_in = sat_comp(z);
   end

   assign rsp_strobe      = out_valid_ff;
   assign rsp_out0        = out0_ff;
   assign rsp_out1        = out1_ff;
   assign rsp_out2        = out2_ff;
   assign rsp_range_error = err_ff;

endmodule

// ===== hw/rtl/rct_checker.sv =====
// Port-level checks for the reversible color transform core, bound to its top level.
module rct_checker
   import rct_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic signed [COMP_W-1:0] req_comp0,
   input logic signed [COMP_W-1:0] req_comp1,
   input logic signed [COMP_W-1:0] req_comp2,
   input logic                 rsp_strobe,
   input logic signed [COMP_W-1:0] rsp_out0,
   input logic signed [COMP_W-1:0] rsp_out1,
   input logic signed [COMP_W-1:0] rsp_out2,
   input logic                 rsp_range_error
);

   localparam logic signed [COMP_W-1:0] MOD_BASE_C = COMP_W'(MOD_BASE);

   a_strobe_follows_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result strobe without an input transfer two cycles before");

   a_transfer_gives_strobe: assert property (@(posedge clock) disable iff (reset)
      ($past(start && !busy && !reset, 2) && $past(!reset)) |-> rsp_strobe)
      else $error("input transfer produced no result");

   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_range_error) |->
         (rsp_out0 == '0 && rsp_out1 == '0 && rsp_out2 == '0))
      else $error("range error with nonzero components");

   a_error_needs_wide_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_range_error) |->
         ($past(req_comp0, 2) >= MOD_BASE_C || $past(req_comp1, 2) >= MOD_BASE_C ||
          $past(req_comp2, 2) >= MOD_BASE_C))
      else $error("range error without a component of 256 or more");

endmodule

bind reversible_color_transform_core rct_checker u_rct_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_comp0       (req_comp0),
   .req_comp1       (req_comp1),
   .req_comp2       (req_comp2),
   .rsp_strobe      (rsp_strobe),
   .rsp_out0        (rsp_out0),
   .rsp_out1        (rsp_out1),
   .rsp_out2        (rsp_out2),
   .rsp_range_error (rsp_range_error)
);
